// File: hw/rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants of the barometric compensation block
// Holds the sample and result transaction types, the configuration register
// indexes and the fixed constants of the integer compensation formula.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // One input transaction: raw temperature and raw pressure readings.
    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } sample_t;

    // One result transaction.
    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic        [19:0] pressure_pa;
        logic               divide_fault;
    } result_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_OVERSAMPLING   = 2'd0,
        CFG_CAL_A_SIGNED   = 2'd1,
        CFG_CAL_A_UNSIGNED = 2'd2,
        CFG_CAL_B_AND_M    = 2'd3
    } cfg_index_t;

    // Constants of the compensation formula.
    localparam int B5_OFFSET   = 4000;
    localparam int CORR_SQ_K   = 3038;
    localparam int CORR_LIN_K  = -7357;
    localparam int CORR_BIAS   = 3791;
    localparam int PRESS_SCALE = 50000;
    localparam int X3_BIAS     = 32768;
    localparam int TEMP_ROUND  = 8;
    localparam int TEMP_MAX    = 32767;
    localparam int TEMP_MIN    = -32768;
    localparam int PRESS_MAX   = 1048575;

endpackage

// File: hw/rtl/bsc_div_pipe.sv
// ----------------------------------------------------------------------------
// bsc_div_pipe: pipelined unsigned restoring divider
// Produces one quotient bit per register stage, so a new division can enter
// in every cycle. A sideband word and a valid bit travel with each operand.
// ----------------------------------------------------------------------------
module bsc_div_pipe #(
    parameter int N = 32,
    parameter int M = 17,
    parameter int W = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [N-1:0] dividend,
    input  logic [M-1:0] divisor,
    input  logic [W-1:0] in_side,
    output logic         out_valid,
    output logic [N-1:0] quotient,
    output logic [W-1:0] out_side
);

    logic [M-1:0] rem_reg  [N];
    logic [N-1:0] quo_reg  [N];
    logic [M-1:0] dvs_reg  [N];
    logic [W-1:0] side_reg [N];
    logic [N-1:0] vld_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [M-1:0] rem_in;
        logic [N-1:0] quo_in;
        logic [M-1:0] dvs_in;
        logic [W-1:0] side_in;
        logic         vld_in;
        logic [M:0]   shifted;
        logic [M+1:0] diff;
        logic         fits;
        logic [M-1:0] rem_next;
        logic [N-1:0] quo_next;

        // Operands come from the port for the first stage, else from the stage before.
        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign quo_in  = dividend;
            assign dvs_in  = divisor;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign dvs_in  = dvs_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        // One trial subtraction decides one quotient bit.
        assign shifted  = {rem_in, quo_in[N-1]};
        assign diff     = {1'b0, shifted} - {2'b00, dvs_in};
        assign fits     = !diff[M+1];
        assign rem_next = fits ? diff[M-1:0] : shifted[M-1:0];
        assign quo_next = {quo_in[N-2:0], fits};

        // The valid bit is control state and is reset.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end

        // Payload registers follow the pipeline without reset.
        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            quo_reg[k]  <= quo_next;
            dvs_reg[k]  <= dvs_in;
            side_reg[k] <= side_in;
        end
    end

    assign out_valid = vld_reg[N-1];
    assign quotient  = quo_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// File: hw/rtl/baro_sensor_int_compensation.sv
// ----------------------------------------------------------------------------
// baro_sensor_int_compensation: integer barometric sensor compensation
// Turns a raw temperature and pressure pair into tenths of a degree and
// pascals with the ten-coefficient fixed-point formula.
// ----------------------------------------------------------------------------
// Usage
// A sample transaction is taken at each rising edge where start is high and
// busy is low. busy is never raised: the block is a fully pipelined datapath
// and takes one sample in every cycle.
// Each result is shown on result for exactly one cycle, marked by
// result_valid; results leave in sample order. The pipeline holds the two
// bit-per-stage dividers (27 stages for the temperature quotient, 32 for the
// pressure quotient) and fifteen arithmetic stages around them, some of which
// hold several multiplies.
// The receiver cannot stall the block, so the pipeline never holds.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, and writes belong to times when no sample is in
// flight. Reset clears all coefficients, the oversampling setting and every
// stage valid bit, so no stale result appears after reset.
// ----------------------------------------------------------------------------
module baro_sensor_int_compensation (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bsc_pkg::sample_t    sample,
    output logic                result_valid,
    output bsc_pkg::result_t    result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  bsc_pkg::cfg_index_t cfg_index,
    input  logic [63:0]         cfg_data
);
    import bsc_pkg::*;

    localparam int TDIV_N  = 27;
    localparam int TDIV_M  = 20;
    localparam int PDIV_N  = 32;
    localparam int PDIV_M  = 17;
    localparam int LATENCY = 2 + TDIV_N + 8 + PDIV_N + 3 + 2;

    typedef struct packed {
        logic signed [18:0] x1;
        logic        [18:0] up;
        logic               neg;
        logic               fault;
    } tdiv_side_t;

    typedef struct packed {
        logic signed [15:0] t;
        logic               fault;
        logic               big;
    } pdiv_side_t;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [1:0]  oss_reg;
    logic [47:0] cal_as_reg;
    logic [47:0] cal_au_reg;
    logic [63:0] cal_bm_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oss_reg    <= '0;
            cal_as_reg <= '0;
            cal_au_reg <= '0;
            cal_bm_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OVERSAMPLING:   oss_reg    <= cfg_data[1:0];
                CFG_CAL_A_SIGNED:   cal_as_reg <= cfg_data[47:0];
                CFG_CAL_A_UNSIGNED: cal_au_reg <= cfg_data[47:0];
                CFG_CAL_B_AND_M:    cal_bm_reg <= cfg_data;
                default:            oss_reg    <= oss_reg;
            endcase
        end
    end

    // Coefficient fields.
    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic        [15:0] ac4, ac5, ac6;

    assign ac1 = cal_as_reg[47:32];
    assign ac2 = cal_as_reg[31:16];
    assign ac3 = cal_as_reg[15:0];
    assign ac4 = cal_au_reg[47:32];
    assign ac5 = cal_au_reg[31:16];
    assign ac6 = cal_au_reg[15:0];
    assign b1  = cal_bm_reg[63:48];
    assign b2  = cal_bm_reg[47:32];
    assign mc  = cal_bm_reg[31:16];
    assign md  = cal_bm_reg[15:0];

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Valid bits of the arithmetic stages.
    // ------------------------------------------------------------------
    logic s0_vld_reg, s1_vld_reg, s2_vld_reg;
    logic s3_vld_reg, s4_vld_reg, s5_vld_reg, s6_vld_reg;
    logic s7_vld_reg, s8_vld_reg, s9_vld_reg, s10_vld_reg;
    logic s12_vld_reg, s13_vld_reg, s14_vld_reg, out_vld_reg;
    logic tdiv_valid, pdiv_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s12_vld_reg <= 1'b0;
            s13_vld_reg <= 1'b0;
            s14_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg  <= accept;
            s1_vld_reg  <= s0_vld_reg;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= tdiv_valid;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= s8_vld_reg;
            s10_vld_reg <= s9_vld_reg;
            s12_vld_reg <= pdiv_valid;
            s13_vld_reg <= s12_vld_reg;
            s14_vld_reg <= s13_vld_reg;
            out_vld_reg <= s14_vld_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: capture the sample.
    // ------------------------------------------------------------------
    logic [15:0] s0_ut_reg;
    logic [18:0] s0_up_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_ut_reg <= sample.raw_temperature;
            s0_up_reg <= sample.raw_pressure;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: (UT - AC6) * AC5.
    // ------------------------------------------------------------------
    logic signed [16:0] s1_diff;
    logic signed [33:0] s1_prod_next, s1_prod_reg;
    logic        [18:0] s1_up_reg;

    assign s1_diff      = $signed({1'b0, s0_ut_reg}) - $signed({1'b0, ac6});
    assign s1_prod_next = 34'(s1_diff) * 34'($signed({1'b0, ac5}));

    always_ff @(posedge clk)
    begin
        s1_prod_reg <= s1_prod_next;
        s1_up_reg   <= s0_up_reg;
    end

    // ------------------------------------------------------------------
    // Stage 2: X1 and the temperature divisor X1 + MD.
    // ------------------------------------------------------------------
    logic signed [18:0] s2_x1_next, s2_x1_reg;
    logic signed [19:0] s2_d_next, s2_d_reg;
    logic        [18:0] s2_up_reg;

    assign s2_x1_next = 19'(s1_prod_reg >>> 15);
    assign s2_d_next  = 20'(s2_x1_next) + 20'(md);

    always_ff @(posedge clk)
    begin
        s2_x1_reg <= s2_x1_next;
        s2_d_reg  <= s2_d_next;
        s2_up_reg <= s1_up_reg;
    end

    // Signed division by magnitudes; the quotient sign is restored afterwards.
    logic [TDIV_M-1:0] tdiv_divisor;
    logic [15:0]       mc_mag;
    logic [TDIV_N-1:0] tdiv_dividend, tdiv_quot;
    tdiv_side_t        tdiv_side_in, tdiv_side_out;

    assign tdiv_divisor       = s2_d_reg[19] ? TDIV_M'(-s2_d_reg) : TDIV_M'(s2_d_reg);
    assign mc_mag             = mc[15] ? 16'(-17'(mc)) : 16'(mc);
    assign tdiv_dividend      = {mc_mag, 11'b0};
    assign tdiv_side_in.x1    = s2_x1_reg;
    assign tdiv_side_in.up    = s2_up_reg;
    assign tdiv_side_in.neg   = mc[15] ^ s2_d_reg[19];
    assign tdiv_side_in.fault = (s2_d_reg == '0);

    bsc_div_pipe #(
        .N (TDIV_N),
        .M (TDIV_M),
        .W ($bits(tdiv_side_t))
    ) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_vld_reg),
        .dividend  (tdiv_dividend),
        .divisor   (tdiv_divisor),
        .in_side   (tdiv_side_in),
        .out_valid (tdiv_valid),
        .quotient  (tdiv_quot),
        .out_side  (tdiv_side_out)
    );

    // ------------------------------------------------------------------
    // Stage 3: X2 with its sign and B5 = X1 + X2.
    // ------------------------------------------------------------------
    logic signed [27:0] s3_x2;
    logic signed [28:0] s3_b5_next, s3_b5_reg;
    logic        [18:0] s3_up_reg;
    logic               s3_fault_reg;

    assign s3_x2      = tdiv_side_out.neg ? -$signed({1'b0, tdiv_quot})
                                          : $signed({1'b0, tdiv_quot});
    assign s3_b5_next = 29'(tdiv_side_out.x1) + 29'(s3_x2);

    always_ff @(posedge clk)
    begin
        s3_b5_reg    <= s3_b5_next;
        s3_up_reg    <= tdiv_side_out.up;
        s3_fault_reg <= tdiv_side_out.fault;
    end

    // ------------------------------------------------------------------
    // Stage 4: saturated temperature and B6.
    // ------------------------------------------------------------------
    logic signed [25:0] s4_t_full;
    logic signed [15:0] s4_t_next, s4_t_reg;
    logic signed [29:0] s4_b6_next, s4_b6_reg;
    logic        [18:0] s4_up_reg;
    logic               s4_fault_reg;

    assign s4_t_full  = 26'((30'(s3_b5_reg) + 30'(TEMP_ROUND)) >>> 4);
    assign s4_b6_next = 30'(s3_b5_reg) - 30'(B5_OFFSET);

    always_comb
    begin
        if (s4_t_full > 26'(TEMP_MAX))
        begin
            s4_t_next = 16'(TEMP_MAX);
        end
        else if (s4_t_full < 26'(TEMP_MIN))
        begin
            s4_t_next = 16'(TEMP_MIN);
        end
        else
        begin
            s4_t_next = 16'(s4_t_full);
        end
    end

    always_ff @(posedge clk)
    begin
        s4_t_reg     <= s4_t_next;
        s4_b6_reg    <= s4_b6_next;
        s4_up_reg    <= s3_up_reg;
        s4_fault_reg <= s3_fault_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: B6 squared, AC2 * B6 and AC3 * B6.
    // ------------------------------------------------------------------
    logic signed [59:0] s5_sqf_reg;
    logic signed [45:0] s5_ac2b6_reg, s5_ac3b6_reg;
    logic signed [15:0] s5_t_reg;
    logic        [18:0] s5_up_reg;
    logic               s5_fault_reg;

    always_ff @(posedge clk)
    begin
        s5_sqf_reg   <= 60'(s4_b6_reg) * 60'(s4_b6_reg);
        s5_ac2b6_reg <= 46'(s4_b6_reg) * 46'(ac2);
        s5_ac3b6_reg <= 46'(s4_b6_reg) * 46'(ac3);
        s5_t_reg     <= s4_t_reg;
        s5_up_reg    <= s4_up_reg;
        s5_fault_reg <= s4_fault_reg;
    end

    // ------------------------------------------------------------------
    // Stage 6: scale the products.
    // ------------------------------------------------------------------
    logic signed [48:0] s6_sq_reg;
    logic signed [34:0] s6_x2a_reg;
    logic signed [32:0] s6_x1c_reg;
    logic signed [15:0] s6_t_reg;
    logic        [18:0] s6_up_reg;
    logic               s6_fault_reg;

    always_ff @(posedge clk)
    begin
        s6_sq_reg    <= 49'(s5_sqf_reg >>> 12);
        s6_x2a_reg   <= 35'(s5_ac2b6_reg >>> 11);
        s6_x1c_reg   <= 33'(s5_ac3b6_reg >>> 13);
        s6_t_reg     <= s5_t_reg;
        s6_up_reg    <= s5_up_reg;
        s6_fault_reg <= s5_fault_reg;
    end

    // ------------------------------------------------------------------
    // Stage 7: B2 * SQ and B1 * SQ.
    // ------------------------------------------------------------------
    logic signed [64:0] s7_b2sq_reg, s7_b1sq_reg;
    logic signed [34:0] s7_x2a_reg;
    logic signed [32:0] s7_x1c_reg;
    logic signed [15:0] s7_t_reg;
    logic        [18:0] s7_up_reg;
    logic               s7_fault_reg;

    always_ff @(posedge clk)
    begin
        s7_b2sq_reg  <= 65'(s6_sq_reg) * 65'(b2);
        s7_b1sq_reg  <= 65'(s6_sq_reg) * 65'(b1);
        s7_x2a_reg   <= s6_x2a_reg;
        s7_x1c_reg   <= s6_x1c_reg;
        s7_t_reg     <= s6_t_reg;
        s7_up_reg    <= s6_up_reg;
        s7_fault_reg <= s6_fault_reg;
    end

    // ------------------------------------------------------------------
    // Stage 8: X3 terms for B3 and for B4.
    // ------------------------------------------------------------------
    logic signed [54:0] s8_x3a_reg;
    logic signed [47:0] s8_x3c_reg;
    logic signed [49:0] s8_x3c_sum;
    logic signed [15:0] s8_t_reg;
    logic        [18:0] s8_up_reg;
    logic               s8_fault_reg;

    assign s8_x3c_sum = 50'(s7_b1sq_reg >>> 16) + 50'(s7_x1c_reg) + 50'sd2;

    always_ff @(posedge clk)
    begin
        s8_x3a_reg   <= 55'(s7_b2sq_reg >>> 11) + 55'(s7_x2a_reg);
        s8_x3c_reg   <= 48'(s8_x3c_sum >>> 2);
        s8_t_reg     <= s7_t_reg;
        s8_up_reg    <= s7_up_reg;
        s8_fault_reg <= s7_fault_reg;
    end

    // ------------------------------------------------------------------
    // Stage 9: B3 (low word) and the B4 product.
    // ------------------------------------------------------------------
    logic signed [58:0] s9_base, s9_shifted;
    logic signed [58:0] s9_b3_full;
    logic        [31:0] s9_x3c_biased;
    logic        [47:0] s9_b4_full;
    logic        [31:0] s9_b3lo_reg, s9_b4p_reg;
    logic signed [15:0] s9_t_reg;
    logic        [18:0] s9_up_reg;
    logic               s9_fault_reg;

    assign s9_base       = (59'(ac1) <<< 2) + 59'(s8_x3a_reg);
    assign s9_shifted    = s9_base <<< oss_reg;
    assign s9_b3_full    = (s9_shifted + 59'sd2) >>> 2;
    assign s9_x3c_biased = 32'(s8_x3c_reg + 48'(X3_BIAS));
    assign s9_b4_full    = {32'b0, ac4} * {16'b0, s9_x3c_biased};

    always_ff @(posedge clk)
    begin
        s9_b3lo_reg  <= s9_b3_full[31:0];
        s9_b4p_reg   <= s9_b4_full[31:0];
        s9_t_reg     <= s8_t_reg;
        s9_up_reg    <= s8_up_reg;
        s9_fault_reg <= s8_fault_reg;
    end

    // ------------------------------------------------------------------
    // Stage 10: B4 (17 bits) and B7 (modulo 2^32).
    // ------------------------------------------------------------------
    logic [31:0]        s10_dlo;
    logic [15:0]        s10_scale;
    logic [47:0]        s10_b7_full;
    logic [16:0]        s10_b4_reg;
    logic [31:0]        s10_b7_reg;
    logic signed [15:0] s10_t_reg;
    logic               s10_fault_reg;

    assign s10_dlo     = {13'b0, s9_up_reg} - s9_b3lo_reg;
    assign s10_scale   = 16'(PRESS_SCALE) >> oss_reg;
    assign s10_b7_full = {16'b0, s10_dlo} * {32'b0, s10_scale};

    always_ff @(posedge clk)
    begin
        s10_b4_reg    <= s9_b4p_reg[31:15];
        s10_b7_reg    <= s10_b7_full[31:0];
        s10_t_reg     <= s9_t_reg;
        s10_fault_reg <= s9_fault_reg;
    end

    // Pressure quotient: 2*B7/B4 for small B7, else (B7/B4)*2.
    logic [PDIV_N-1:0] pdiv_dividend, pdiv_quot;
    pdiv_side_t        pdiv_side_in, pdiv_side_out;

    assign pdiv_side_in.big   = s10_b7_reg[31];
    assign pdiv_side_in.t     = s10_t_reg;
    assign pdiv_side_in.fault = s10_fault_reg || (s10_b4_reg == '0);
    assign pdiv_dividend      = s10_b7_reg[31] ? s10_b7_reg : {s10_b7_reg[30:0], 1'b0};

    bsc_div_pipe #(
        .N (PDIV_N),
        .M (PDIV_M),
        .W ($bits(pdiv_side_t))
    ) u_pdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s10_vld_reg),
        .dividend  (pdiv_dividend),
        .divisor   (s10_b4_reg),
        .in_side   (pdiv_side_in),
        .out_valid (pdiv_valid),
        .quotient  (pdiv_quot),
        .out_side  (pdiv_side_out)
    );

    // ------------------------------------------------------------------
    // Stage 12: (P>>8) squared and -7357 * P.
    // ------------------------------------------------------------------
    logic [32:0]        s12_p;
    logic [32:0]        s12_p_reg;
    logic [49:0]        s12_sq_reg;
    logic signed [47:0] s12_lin_reg;
    logic signed [15:0] s12_t_reg;
    logic               s12_fault_reg;

    assign s12_p = pdiv_side_out.big ? {pdiv_quot, 1'b0} : {1'b0, pdiv_quot};

    always_ff @(posedge clk)
    begin
        s12_p_reg     <= s12_p;
        s12_sq_reg    <= {25'b0, s12_p[32:8]} * {25'b0, s12_p[32:8]};
        s12_lin_reg   <= 48'($signed({1'b0, s12_p})) * 48'(CORR_LIN_K);
        s12_t_reg     <= pdiv_side_out.t;
        s12_fault_reg <= pdiv_side_out.fault;
    end

    // ------------------------------------------------------------------
    // Stage 13: scale both correction terms.
    // ------------------------------------------------------------------
    logic [61:0]        s13_sqk;
    logic [45:0]        s13_x1_reg;
    logic signed [31:0] s13_x2_reg;
    logic [32:0]        s13_p_reg;
    logic signed [15:0] s13_t_reg;
    logic               s13_fault_reg;

    assign s13_sqk = {12'b0, s12_sq_reg} * 62'(CORR_SQ_K);

    always_ff @(posedge clk)
    begin
        s13_x1_reg    <= s13_sqk[61:16];
        s13_x2_reg    <= 32'(s12_lin_reg >>> 16);
        s13_p_reg     <= s12_p_reg;
        s13_t_reg     <= s12_t_reg;
        s13_fault_reg <= s12_fault_reg;
    end

    // ------------------------------------------------------------------
    // Stage 14: apply the final correction.
    // ------------------------------------------------------------------
    logic signed [47:0] s14_sum, s14_corr;
    logic signed [47:0] s14_pf_reg;
    logic signed [15:0] s14_t_reg;
    logic               s14_fault_reg;

    assign s14_sum  = $signed({2'b0, s13_x1_reg}) + 48'(s13_x2_reg) + 48'(CORR_BIAS);
    assign s14_corr = s14_sum >>> 4;

    always_ff @(posedge clk)
    begin
        s14_pf_reg    <= $signed({15'b0, s13_p_reg}) + s14_corr;
        s14_t_reg     <= s13_t_reg;
        s14_fault_reg <= s13_fault_reg;
    end

    // ------------------------------------------------------------------
    // Output register: saturation and fault zeroing.
    // ------------------------------------------------------------------
    result_t res_next, res_reg;

    always_comb
    begin
        res_next.divide_fault       = s14_fault_reg;
        res_next.temperature_tenths = s14_t_reg;
        if (s14_pf_reg < 48'sd0)
        begin
            res_next.pressure_pa = '0;
        end
        else if (s14_pf_reg > 48'(PRESS_MAX))
        begin
            res_next.pressure_pa = 20'(PRESS_MAX);
        end
        else
        begin
            res_next.pressure_pa = s14_pf_reg[19:0];
        end
        if (s14_fault_reg)
        begin
            res_next.temperature_tenths = '0;
            res_next.pressure_pa        = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = out_vld_reg;
    assign result       = res_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // Every accepted sample leaves after the fixed pipeline latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY result_valid)
        else $error("result missing at the expected latency");

    // A faulted transaction carries zero readings.
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.divide_fault |->
            (result.temperature_tenths == '0) && (result.pressure_pa == '0))
        else $error("faulted result with non-zero readings");

    // The pressure divider only sees work that passed the temperature divider.
    a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
        pdiv_valid |-> $past(tdiv_valid, PDIV_N + 8))
        else $error("pressure quotient without a matching temperature quotient");

endmodule
